// File: rtl/core/ptdu_pkg.sv
// ----------------------------------------------------------------------------
// Prime test package
// Shared constants for the trial-division primality tester.
// ----------------------------------------------------------------------------
package ptdu_pkg;

    // Default width of the tested integer.
    localparam int DEF_VALUE_WIDTH = 32;

    // The modulus of the first filter and the step between divisor pairs.
    localparam int WHEEL_MODULUS = 6;

    // First divisor of the 6k-1 / 6k+1 sequence.
    localparam int FIRST_DIVISOR = 5;

    // Offset of the second divisor of a pair.
    localparam int PAIR_OFFSET = 2;

    // Residues modulo 6 that can still belong to a prime.
    localparam int RESIDUE_LOW  = 1;
    localparam int RESIDUE_HIGH = 5;

    // Smallest values handled without division.
    localparam int SMALL_PRIME_A = 2;
    localparam int SMALL_PRIME_B = 3;
    localparam int SMALL_LIMIT   = 4;

endpackage

// File: rtl/core/prime_test_trial_division_unit.sv
// ----------------------------------------------------------------------------
// Prime test by trial division
// Tests one signed integer for primality with 6k-1 / 6k+1 divisor pairs,
// using a single bit-serial restoring divider under a small sequencer.
// ----------------------------------------------------------------------------
// Use: drive value and raise start while busy is low; the request is taken at
// that clock edge. The answer appears on is_prime, marked by done, which is high for
// a single cycle. The receiver cannot stall, so the result must be taken in
// that cycle.
// Negative values, values up to 4, 2 and 3 are settled at once: done rises
// in the cycle after the request and busy never goes high.
// Every other value runs through one shared divider that produces one
// quotient bit per cycle: each division runs VALUE_WIDTH shift steps and
// then one evaluation step. A test needs one division by 6 and then up to
// two divisions per divisor pair. For 32-bit values the worst case is about
// 7700 pairs. The divider is the sole limit on rate; busy stays high
// throughout.
// A new request may be given in the cycle in which done is high.
// Reset returns the sequencer to idle and discards any test in progress.
// ----------------------------------------------------------------------------
module prime_test_trial_division_unit #(
    parameter int VALUE_WIDTH = ptdu_pkg::DEF_VALUE_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [VALUE_WIDTH-1:0] value,
    output logic                          busy,
    output logic                          done,
    output logic                          is_prime
);

    // The last divisor used stays below the square root of the value plus six.
    localparam int DW = (VALUE_WIDTH + 1) / 2 + 1;
    localparam int CW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;

    localparam logic [1:0] PH_MOD6 = 2'd0;
    localparam logic [1:0] PH_LOW  = 2'd1;
    localparam logic [1:0] PH_HIGH = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [1:0]             phase_reg, phase_next;
    logic                   done_reg, done_next;
    logic [CW-1:0]          cnt_reg, cnt_next;

    logic [VALUE_WIDTH-1:0] n_reg, n_next;
    logic [DW-1:0]          d_reg, d_next;
    logic [DW-1:0]          dvsr_reg, dvsr_next;
    logic [VALUE_WIDTH-1:0] quo_reg, quo_next;
    logic [DW-1:0]          rem_reg, rem_next;
    logic                   prime_reg, prime_next;

    logic [DW:0]            trial;
    logic [DW:0]            diff;
    logic                   fits;
    logic [VALUE_WIDTH-1:0] raw;

    assign raw   = VALUE_WIDTH'(value);
    assign trial = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign diff  = trial - {1'b0, dvsr_reg};
    assign fits  = ~diff[DW];

    always_comb
    begin
        logic          launch;
        logic          finish;
        logic          verdict;
        logic [DW-1:0] launch_dvsr;

        launch      = 1'b0;
        finish      = 1'b0;
        verdict     = 1'b0;
        launch_dvsr = dvsr_reg;

        state_next = state_reg;
        phase_next = phase_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        dvsr_next  = dvsr_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        prime_next = prime_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    n_next = raw;
                    d_next = DW'(ptdu_pkg::FIRST_DIVISOR);
                    if (raw[VALUE_WIDTH-1])
                    begin
                        finish = 1'b1;
                    end
                    else if (raw == VALUE_WIDTH'(ptdu_pkg::SMALL_PRIME_A) ||
                             raw == VALUE_WIDTH'(ptdu_pkg::SMALL_PRIME_B))
                    begin
                        finish  = 1'b1;
                        verdict = 1'b1;
                    end
                    else if (raw <= VALUE_WIDTH'(ptdu_pkg::SMALL_LIMIT))
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_MOD6;
                        dvsr_next  = DW'(ptdu_pkg::WHEEL_MODULUS);
                        quo_next   = raw;
                        rem_next   = '0;
                        cnt_next   = '0;
                        state_next = S_DIV;
                    end
                end
            end

            S_DIV:
            begin
                quo_next = {quo_reg[VALUE_WIDTH-2:0], fits};
                rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(VALUE_WIDTH - 1))
                begin
                    state_next = S_EVAL;
                end
            end

            S_EVAL:
            begin
                case (phase_reg)
                    PH_MOD6:
                    begin
                        if (rem_reg == DW'(ptdu_pkg::RESIDUE_LOW) ||
                            rem_reg == DW'(ptdu_pkg::RESIDUE_HIGH))
                        begin
                            phase_next  = PH_LOW;
                            launch      = 1'b1;
                            launch_dvsr = d_reg;
                        end
                        else
                        begin
                            finish = 1'b1;
                        end
                    end

                    PH_LOW:
                    begin
                        // Quotient below the divisor means d*d exceeds the value.
                        if (quo_reg < VALUE_WIDTH'(d_reg))
                        begin
                            finish  = 1'b1;
                            verdict = 1'b1;
                        end
                        else if (rem_reg == '0)
                        begin
                            finish = 1'b1;
                        end
                        else
                        begin
                            phase_next  = PH_HIGH;
                            launch      = 1'b1;
                            launch_dvsr = d_reg + DW'(ptdu_pkg::PAIR_OFFSET);
                        end
                    end

                    PH_HIGH:
                    begin
                        if (rem_reg == '0)
                        begin
                            finish = 1'b1;
                        end
                        else
                        begin
                            d_next      = d_reg + DW'(ptdu_pkg::WHEEL_MODULUS);
                            phase_next  = PH_LOW;
                            launch      = 1'b1;
                            launch_dvsr = d_reg + DW'(ptdu_pkg::WHEEL_MODULUS);
                        end
                    end

                    default:
                    begin
                        finish = 1'b1;
                    end
                endcase
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (launch)
        begin
            dvsr_next  = launch_dvsr;
            quo_next   = n_reg;
            rem_next   = '0;
            cnt_next   = '0;
            state_next = S_DIV;
        end

        if (finish)
        begin
            done_next  = 1'b1;
            prime_next = verdict;
            state_next = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_MOD6;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        d_reg     <= d_next;
        dvsr_reg  <= dvsr_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        prime_reg <= prime_next;
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign is_prime = prime_reg;

    // A result only follows a request or a running test.
    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(start) || $past(busy)))
        else $error("result strobe without a request or a running test");

    // The sequencer is idle whenever a result is shown.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a test is still running");

    // The divider never runs with a zero divisor.
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (dvsr_reg != '0))
        else $error("division started with a zero divisor");

    // Restoring division keeps the partial remainder below the divisor.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV || state_reg == S_EVAL) |-> (rem_reg < dvsr_reg))
        else $error("partial remainder reached the divisor");

    // Each division runs for exactly one step per value bit.
    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && state_next == S_EVAL) |->
            (cnt_reg == CW'(VALUE_WIDTH - 1)))
        else $error("division left before its last step");

endmodule
